// ===== src/mst_pkg.sv =====
// Shared types, constants and helpers for the minimum spanning tree core.
package mst_pkg;

	localparam int MAX_VERTICES_DEF = 32;
	localparam int MAX_EDGES_DEF    = 256;
	localparam int VIDX_W           = 5;
	localparam int WEIGHT_W         = 16;
	localparam int VCOUNT_W         = 6;
	localparam int EDGE_W           = 2 * VIDX_W + WEIGHT_W;
	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;

	typedef struct packed {
		logic [VIDX_W-1:0]          edge_source;
		logic [VIDX_W-1:0]          edge_dest;
		logic signed [WEIGHT_W-1:0] edge_weight;
		logic                       last_edge_in;
	} edge_in_t;

	typedef struct packed {
		logic [VIDX_W-1:0]          low_vertex;
		logic [VIDX_W-1:0]          high_vertex;
		logic signed [WEIGHT_W-1:0] tree_weight;
		logic                       last_tree_edge;
		logic                       spanning_complete;
		logic                       edges_dropped;
	} tree_out_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // store incoming edge
		logic clr;         // clear graph state
		logic sort_init;   // i <= 0
		logic sort_begin;  // j <= i
		logic sort_key;    // latch key of edge i
		logic sort_cmp;    // shift or place
		logic walk_init;   // k <= 0
		logic walk_chk;    // range test, seed roots
		logic find_step;   // one parent hop on both roots
		logic walk_join;   // link and record if roots differ
		logic emit;        // send one recorded tree edge
		logic emit_marker; // single empty result
	} mst_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;        // last flag on loaded item
		logic sort_done;   // i reached total
		logic sort_first;  // j is zero
		logic sort_place;  // insertion point found
		logic walk_done;   // edges exhausted or tree full
		logic out_range;   // endpoint out of range
		logic roots_found; // both finds ended
		logic any_chosen;
		logic emit_last;   // final recorded tree edge
	} mst_stat_t;

	// ordered key: signed weight flipped to unsigned
	function automatic logic [WEIGHT_W-1:0] wkey(input logic [WEIGHT_W-1:0] w);
		wkey = w ^ {1'b1, {(WEIGHT_W-1){1'b0}}};
	endfunction

endpackage

// ===== src/mst_ram.sv =====
// Generic single write, single registered read RAM.
module mst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/mst_ctrl.sv =====
// Sequencer for load, insertion sort, union-find walk and result output.
module mst_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output mst_pkg::mst_cmd_t    cmd,
	input  mst_pkg::mst_stat_t   stat
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_LOAD   = 4'd1;
	localparam logic [3:0] S_SORTI  = 4'd2;
	localparam logic [3:0] S_SKEY   = 4'd3;
	localparam logic [3:0] S_SRD    = 4'd4;
	localparam logic [3:0] S_SWAIT  = 4'd5;
	localparam logic [3:0] S_SCMP   = 4'd6;
	localparam logic [3:0] S_WRD    = 4'd7;
	localparam logic [3:0] S_WWAIT  = 4'd8;
	localparam logic [3:0] S_WCHK   = 4'd9;
	localparam logic [3:0] S_FIND   = 4'd10;
	localparam logic [3:0] S_ORD    = 4'd11;
	localparam logic [3:0] S_OEMIT  = 4'd12;
	localparam logic [3:0] S_MARK   = 4'd13;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_LOAD;
				end
			end
			S_LOAD: begin
				if (stat.last) begin
					cmd.sort_init = 1'b1;
					state_d       = S_SORTI;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SORTI: begin
				if (stat.sort_done) begin
					cmd.walk_init = 1'b1;
					state_d       = S_WRD;
				end else begin
					cmd.sort_begin = 1'b1;
					state_d        = S_SKEY;
				end
			end
			S_SKEY: begin
				cmd.sort_key = 1'b1;
				state_d      = S_SRD;
			end
			S_SRD: begin
				if (stat.sort_first) begin
					cmd.sort_cmp = 1'b1;
					state_d      = S_SORTI;
				end else begin
					state_d = S_SWAIT;
				end
			end
			S_SWAIT: state_d = S_SCMP;
			S_SCMP: begin
				cmd.sort_cmp = 1'b1;
				state_d      = stat.sort_place ? S_SORTI : S_SRD;
			end
			S_WRD: begin
				if (stat.walk_done) begin
					state_d = stat.any_chosen ? S_ORD : S_MARK;
				end else begin
					state_d = S_WWAIT;
				end
			end
			S_WWAIT: state_d = S_WCHK;
			S_WCHK: begin
				cmd.walk_chk = 1'b1;
				state_d      = stat.out_range ? S_WRD : S_FIND;
			end
			S_FIND: begin
				if (stat.roots_found) begin
					cmd.walk_join = 1'b1;
					state_d       = S_WRD;
				end else begin
					cmd.find_step = 1'b1;
				end
			end
			S_ORD: state_d = S_OEMIT;
			S_OEMIT: begin
				cmd.emit = 1'b1;
				if (stat.emit_last) begin
					cmd.clr = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_ORD;
				end
			end
			S_MARK: begin
				cmd.emit_marker = 1'b1;
				cmd.clr         = 1'b1;
				state_d         = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ===== src/mst_dp.sv =====
// Edge store, order list, parent links, tree buffer and result register.
module mst_dp #(
	parameter int MAX_VERTICES = mst_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = mst_pkg::MAX_EDGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mst_pkg::edge_in_t               item,
	input  logic [mst_pkg::VCOUNT_W-1:0]    vcount,
	input  mst_pkg::mst_cmd_t               cmd,
	output mst_pkg::mst_stat_t              stat,
	output logic                            result_valid,
	output mst_pkg::tree_out_t              result
);
	localparam int AW  = $clog2(MAX_EDGES);
	localparam int CW  = $clog2(MAX_EDGES + 1);
	localparam int VN  = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
	localparam int BW  = $clog2(VN);
	localparam int VW  = mst_pkg::VIDX_W;
	localparam int WW  = mst_pkg::WEIGHT_W;
	localparam int EW  = mst_pkg::EDGE_W;
	localparam int NW  = mst_pkg::VCOUNT_W;
	localparam int HW  = $clog2(VN + 1);

	logic [CW-1:0] total_q, i_q, j_q, k_q;
	logic          ovf_q, last_q, walk_q;
	logic [VW-1:0] chosen_q, idx_q;
	logic [VW-1:0] parent_q [VN];
	logic [VW-1:0] rs_q, rd_q;
	logic [HW-1:0] hops_q;
	logic [WW-1:0] keyi_q;
	logic [EW-1:0] cur_q;

	// edge store, two images for two read addresses
	logic          e_we;
	logic [EW-1:0] e_wd, e_rd, e_rd_o;
	// order list
	logic          o_we;
	logic [AW-1:0] o_wa, o_ra, o_wd, o_rd;
	// chosen tree edges
	logic [EW-1:0] b_wd, b_rd;

	logic [VW-1:0] need;
	logic [NW-1:0] nclamp;
	logic [WW-1:0] keyj;
	logic [VW-1:0] s_w, d_w, ps, pd, lo_w, hi_w;
	logic          join_w;
	mst_pkg::tree_out_t res_d;

	always_comb begin
		nclamp = vcount;
		if (vcount < NW'(2))  nclamp = NW'(2);
		if (vcount > NW'(VN)) nclamp = NW'(VN);
		need = VW'(nclamp - NW'(1));
	end

	assign e_we = cmd.load && (total_q < CW'(MAX_EDGES));
	assign e_wd = {item.edge_source, item.edge_dest, item.edge_weight};

	assign o_we = cmd.sort_cmp;
	assign o_wa = j_q[AW-1:0];
	assign o_wd = stat.sort_place ? i_q[AW-1:0] : o_rd;
	assign o_ra = walk_q ? k_q[AW-1:0] : AW'(j_q - CW'(1));

	mst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_estore (
		.clk(clk), .we(e_we), .waddr(total_q[AW-1:0]), .wdata(e_wd),
		.raddr(i_q[AW-1:0]), .rdata(e_rd)
	);
	mst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_estore2 (
		.clk(clk), .we(e_we), .waddr(total_q[AW-1:0]), .wdata(e_wd),
		.raddr(o_rd), .rdata(e_rd_o)
	);
	mst_ram #(.WIDTH(AW), .DEPTH(MAX_EDGES)) u_order (
		.clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd),
		.raddr(o_ra), .rdata(o_rd)
	);
	mst_ram #(.WIDTH(EW), .DEPTH(VN)) u_tree (
		.clk(clk), .we(join_w), .waddr(chosen_q[BW-1:0]), .wdata(b_wd),
		.raddr(idx_q[BW-1:0]), .rdata(b_rd)
	);

	assign keyj = mst_pkg::wkey(e_rd_o[WW-1:0]);

	assign s_w  = cur_q[EW-1 -: VW];
	assign d_w  = cur_q[EW-1-VW -: VW];
	assign lo_w = (s_w < d_w) ? s_w : d_w;
	assign hi_w = (s_w < d_w) ? d_w : s_w;
	assign b_wd = {lo_w, hi_w, cur_q[WW-1:0]};
	assign ps   = parent_q[rs_q];
	assign pd   = parent_q[rd_q];
	assign join_w = cmd.walk_join && (rs_q != rd_q);

	assign stat.last        = last_q;
	assign stat.sort_done   = (i_q >= total_q);
	assign stat.sort_first  = (j_q == '0);
	assign stat.sort_place  = (j_q == '0) || !(keyj > keyi_q);
	assign stat.walk_done   = (k_q >= total_q) || (chosen_q == need);
	assign stat.out_range   = ({1'b0, e_rd_o[EW-1 -: VW]} >= nclamp) ||
	                          ({1'b0, e_rd_o[EW-1-VW -: VW]} >= nclamp);
	assign stat.roots_found = ((ps == rs_q) && (pd == rd_q)) || (hops_q >= HW'(VN));
	assign stat.any_chosen  = (chosen_q != '0);
	assign stat.emit_last   = (idx_q == chosen_q - VW'(1));

	always_comb begin
		res_d                   = '0;
		res_d.last_tree_edge    = 1'b1;
		res_d.spanning_complete = (chosen_q == need);
		res_d.edges_dropped     = ovf_q;
		if (cmd.emit) begin
			res_d.low_vertex     = b_rd[EW-1 -: VW];
			res_d.high_vertex    = b_rd[EW-1-VW -: VW];
			res_d.tree_weight    = b_rd[WW-1:0];
			res_d.last_tree_edge = stat.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			ovf_q    <= 1'b0;
			last_q   <= 1'b0;
			walk_q   <= 1'b0;
			chosen_q <= '0;
			idx_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			rs_q     <= '0;
			rd_q     <= '0;
			hops_q   <= '0;
			keyi_q   <= '0;
			cur_q    <= '0;
			result_valid <= 1'b0;
			result   <= '0;
			for (int v = 0; v < VN; v++) parent_q[v] <= VW'(v);
		end else begin
			result_valid <= cmd.emit || cmd.emit_marker;
			if (cmd.emit || cmd.emit_marker) result <= res_d;
			if (cmd.load) last_q <= item.last_edge_in;
			if (cmd.sort_init) begin
				i_q <= '0;
			end else if (cmd.sort_cmp && stat.sort_place) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.sort_begin) begin
				j_q <= i_q;
			end else if (cmd.sort_cmp && !stat.sort_place) begin
				j_q <= j_q - CW'(1);
			end
			if (cmd.sort_key) keyi_q <= mst_pkg::wkey(e_rd[WW-1:0]);
			if (cmd.walk_init) begin
				k_q <= '0;
			end else if (cmd.walk_chk) begin
				k_q <= k_q + CW'(1);
			end
			if (cmd.walk_chk) begin
				cur_q  <= e_rd_o;
				rs_q   <= e_rd_o[EW-1 -: VW];
				rd_q   <= e_rd_o[EW-1-VW -: VW];
				hops_q <= '0;
			end else if (cmd.find_step) begin
				rs_q   <= ps;
				rd_q   <= pd;
				hops_q <= hops_q + HW'(1);
			end
			if (cmd.clr) begin
				total_q  <= '0;
				ovf_q    <= 1'b0;
				walk_q   <= 1'b0;
				chosen_q <= '0;
				idx_q    <= '0;
				for (int v = 0; v < VN; v++) parent_q[v] <= VW'(v);
			end else begin
				if (cmd.load) begin
					if (e_we) total_q <= total_q + CW'(1);
					else      ovf_q   <= 1'b1;
				end
				if (cmd.walk_init) walk_q <= 1'b1;
				if (join_w) begin
					parent_q[rs_q] <= rd_q;
					chosen_q       <= chosen_q + VW'(1);
				end
				if (cmd.emit) idx_q <= idx_q + VW'(1);
			end
		end
	end
endmodule

// ===== src/minimum_spanning_tree_core.sv =====
// Top level of the minimum spanning tree core.
// Each edge is accepted while idle, followed by a busy load state; after the last
// edge, the core insertion-sorts the edges by weight, then walks them in order,
// following parent links for in-range edges and joining roots that differ.
// Throughput: one graph at a time; results leave as one-cycle strobes the
// receiver cannot stall, the last in the same cycle as busy falls.
// Reset clears all graph state, vcount_q returns to 32.
module minimum_spanning_tree_core #(
	parameter int MAX_VERTICES = mst_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = mst_pkg::MAX_EDGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  mst_pkg::edge_in_t            item,
	output logic                         result_strobe,
	output mst_pkg::tree_out_t           result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mst_pkg::VCOUNT_W-1:0] cfg_data
);
	logic [mst_pkg::VCOUNT_W-1:0] vcount_q;
	mst_pkg::mst_cmd_t  cmd;
	mst_pkg::mst_stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= mst_pkg::VCOUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			vcount_q <= cfg_data;
		end
	end

	mst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .stat(stat)
	);

	mst_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .vcount(vcount_q),
		.cmd(cmd), .stat(stat), .result_valid(result_strobe), .result(result)
	);
endmodule
